@@ hw/rtl/hpd_pkg.sv @@
// Package with shared constants, types and codes for the heading PID drive block.
`timescale 1ns / 1ps

package hpd_pkg;

    localparam int SUM_BITS = 32;
    // PID numerator width: the integral product plus headroom for the P and D terms.
    localparam int ACC_BITS = (SUM_BITS + 18 > 50) ? SUM_BITS + 18 : 50;
    localparam int DIV_BITS = 24;
    localparam longint PID_DEN  = 2560000;
    localparam int PID_SAT  = 4096;
    localparam int COMP_ONE = 4096;

    // Battery code times 880 over 273 equals code times 13200 over 4095.
    localparam logic [21:0] MV_SCALE = 22'd880;
    localparam logic [23:0] MV_RECIP = 24'd15732481;  // ceil(2^32 / 273)

    // Compensation window (6.0 V to 8.4 V) expressed on the code times 880.
    localparam logic [21:0] COMP_LO = 22'd1638000;
    localparam logic [21:0] COMP_HI = 22'd2293200;

    // floor(8400 * 4095 * 4096 / 13200); dividing it by the code gives the factor.
    localparam logic [DIV_BITS-1:0] COMP_NUM = DIV_BITS'(10673803);

    // PID quotient: 2560000 is 4096 * 625, so shift by 12 and take the reciprocal of 625.
    localparam logic [33:0] PID_SAT_MAG = 34'd10485760000;  // 4096 * 2560000
    localparam logic [22:0] PID_RECIP   = 23'd6871948;      // ceil(2^32 / 625)

    // Configuration register indexes.
    localparam logic [2:0] REG_RUN_ENABLE = 3'd0;
    localparam logic [2:0] REG_TARGET     = 3'd1;
    localparam logic [2:0] REG_GAIN_P     = 3'd2;
    localparam logic [2:0] REG_GAIN_I     = 3'd3;
    localparam logic [2:0] REG_GAIN_D     = 3'd4;
    localparam logic [2:0] REG_SPEED_LIM  = 3'd5;
    localparam logic [2:0] REG_CRUISE     = 3'd6;

    // Datapath operations, one per controller state.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MV,
        OP_SUM,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_PID_MAG,
        OP_PID_Q,
        OP_MIX,
        OP_COMP,
        OP_MUL_L,
        OP_MUL_R,
        OP_CLAMP
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV,
        S_SUM,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_PID_MAG,
        S_PID_Q,
        S_MIX,
        S_COMP_WAIT,
        S_MUL_L,
        S_MUL_R,
        S_CLAMP,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

@@ hw/rtl/heading_pid_drive_with_battery_comp_top.sv @@
// Top level of the heading PID drive with battery compensation.
`timescale 1ns / 1ps

// Each tick transfer carries a yaw angle and a battery code. With run_enable set
// it yields one transfer of wheel commands, compensation factor and battery
// millivolts; with it clear the tick is consumed and nothing comes out. Ticks are
// taken only while the block is idle. After the accepting edge, the MV step starts
// the 24-step compensation division, which runs beside the PID steps; the controller
// waits for it to report completion, then the left product, right product and clamp
// steps scale and clamp the commands before the result is offered. The next tick is
// taken in the cycle after the result transfer; no new tick is taken while the result
// waits on stall.
module heading_pid_drive_with_battery_comp_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_yaw_angle,
    input  logic [11:0]        i_battery_code,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [9:0]  o_left_cmd,
    output logic signed [9:0]  o_right_cmd,
    output logic [12:0]        o_comp_factor,
    output logic [13:0]        o_battery_mv
);
    hpd_pkg::t_cmd    w_cmd;
    hpd_pkg::t_status w_status;
    logic             w_run;

    hpd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall      (i_stall),
        .i_run_enable (w_run),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_in_stall   (o_stall),
        .o_valid      (o_valid)
    );

    hpd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_yaw_angle    (i_yaw_angle),
        .i_battery_code (i_battery_code),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_run_enable   (w_run),
        .o_left_cmd     (o_left_cmd),
        .o_right_cmd    (o_right_cmd),
        .o_comp_factor  (o_comp_factor),
        .o_battery_mv   (o_battery_mv)
    );
endmodule

@@ hw/rtl/hpd_div.sv @@
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
`timescale 1ns / 1ps

module hpd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hpd_pkg::DIV_BITS-1:0] i_num,
    input  logic [hpd_pkg::DIV_BITS-1:0] i_den,
    output logic [hpd_pkg::DIV_BITS-1:0] o_quo,
    output logic                         o_done
);
    localparam int CW = $clog2(hpd_pkg::DIV_BITS + 1);

    logic [hpd_pkg::DIV_BITS-1:0] r_quo, r_rem, r_den;
    logic [CW-1:0]                r_cnt;
    logic                         r_busy, r_done;
    logic [hpd_pkg::DIV_BITS:0]   w_trial;

    assign w_trial = {r_rem, r_quo[hpd_pkg::DIV_BITS-1]} - {1'b0, r_den};

    // Shift in one numerator bit and subtract when it fits; done stays high until the next start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CW'(hpd_pkg::DIV_BITS);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_trial[hpd_pkg::DIV_BITS]) begin
                    r_rem <= w_trial[hpd_pkg::DIV_BITS-1:0];
                    r_quo <= {r_quo[hpd_pkg::DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[hpd_pkg::DIV_BITS-2:0], r_quo[hpd_pkg::DIV_BITS-1]};
                    r_quo <= {r_quo[hpd_pkg::DIV_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

@@ hw/rtl/hpd_datapath.sv @@
// Datapath: configuration registers, PID state, multipliers and the compensation divider.
`timescale 1ns / 1ps

module hpd_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic signed [15:0]  i_yaw_angle,
    input  logic [11:0]         i_battery_code,
    input  hpd_pkg::t_cmd       i_cmd,
    output hpd_pkg::t_status    o_status,
    output logic                o_run_enable,
    output logic signed [9:0]   o_left_cmd,
    output logic signed [9:0]   o_right_cmd,
    output logic [12:0]         o_comp_factor,
    output logic [13:0]         o_battery_mv
);
    localparam int W  = hpd_pkg::ACC_BITS;
    localparam int SB = hpd_pkg::SUM_BITS;
    localparam int DB = hpd_pkg::DIV_BITS;

    logic               r_run;
    logic signed [15:0] r_target;
    logic [15:0]        r_kp, r_ki, r_kd;
    logic [8:0]         r_lim, r_cruise;

    logic signed [SB-1:0] r_sum;
    logic signed [16:0]   r_prev;

    logic [11:0]         r_code;
    logic [21:0]         r_x880;
    logic signed [16:0]  r_err;
    logic signed [W-1:0] r_acc;
    logic                r_neg, r_sat;
    logic [21:0]         r_mag_hi;
    logic signed [13:0]  r_pid;
    logic signed [14:0]  r_side_l, r_side_r;
    logic signed [28:0]  r_prod_l, r_prod_r;
    logic [12:0]         r_comp;
    logic [13:0]         r_mv;
    logic signed [9:0]   r_left, r_right;
    logic                r_in_range;

    logic [DB-1:0]        w_quo;
    logic                 w_div_done;

    logic signed [SB:0]   w_sum_ext;
    logic signed [SB-1:0] w_sum_sat;
    logic signed [17:0]   w_diff;
    logic [W-1:0]         w_acc_mag;
    logic [45:0]          w_mv_prod;
    logic [44:0]          w_q_prod;
    logic [12:0]          w_pid_mag;

    // Truncate toward zero by 4096, then clamp to the speed limit.
    function automatic logic signed [9:0] clamp(input logic signed [28:0] p);
        logic signed [28:0] t;
        logic signed [16:0] q;
        logic signed [16:0] lim;
        t   = p[28] ? p + 29'sd4095 : p;
        q   = t[28:12];
        lim = 17'(r_lim);
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return q[9:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_target <= 16'sd3000;
            r_kp     <= 16'd256;
            r_ki     <= 16'd0;
            r_kd     <= 16'd26;
            r_lim    <= 9'd300;
            r_cruise <= 9'd150;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hpd_pkg::REG_RUN_ENABLE: r_run    <= i_cfg_data[0];
                hpd_pkg::REG_TARGET:     r_target <= i_cfg_data;
                hpd_pkg::REG_GAIN_P:     r_kp     <= i_cfg_data;
                hpd_pkg::REG_GAIN_I:     r_ki     <= i_cfg_data;
                hpd_pkg::REG_GAIN_D:     r_kd     <= i_cfg_data;
                hpd_pkg::REG_SPEED_LIM:  r_lim    <= i_cfg_data[8:0];
                hpd_pkg::REG_CRUISE:     r_cruise <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_sum_ext = {r_sum[SB-1], r_sum} + (SB+1)'(r_err);
    assign w_sum_sat = (w_sum_ext[SB] != w_sum_ext[SB-1]) ?
                       {w_sum_ext[SB], {(SB-1){~w_sum_ext[SB]}}} : w_sum_ext[SB-1:0];
    assign w_diff    = 18'(r_err) - 18'(r_prev);
    assign w_acc_mag = r_acc[W-1] ? W'(-r_acc) : W'(r_acc);

    // Reciprocal multiplications for the constant divisions.
    assign w_mv_prod = r_x880 * hpd_pkg::MV_RECIP;
    assign w_q_prod  = r_mag_hi * hpd_pkg::PID_RECIP;
    assign w_pid_mag = r_sat ? 13'(hpd_pkg::PID_SAT) : w_q_prod[44:32];

    // The compensation divider runs beside the PID steps.
    hpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (hpd_pkg::COMP_NUM),
        .i_den   (DB'(r_code)),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // Step registers, one operation per command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else begin
            case (i_cmd.op)
                hpd_pkg::OP_LOAD: begin
                    r_code <= i_battery_code;
                    r_x880 <= 22'(i_battery_code) * hpd_pkg::MV_SCALE;
                    r_err  <= 17'(r_target) - 17'(i_yaw_angle);
                end
                hpd_pkg::OP_MV: begin
                    r_in_range <= (r_x880 >= hpd_pkg::COMP_LO) && (r_x880 <= hpd_pkg::COMP_HI);
                    r_mv       <= w_mv_prod[45:32];
                end
                hpd_pkg::OP_SUM:   r_sum <= w_sum_sat;
                hpd_pkg::OP_MUL_P: r_acc <= W'($signed({1'b0, r_kp}) * r_err) * W'(100);
                hpd_pkg::OP_MUL_I: r_acc <= r_acc + W'($signed({1'b0, r_ki}) * r_sum);
                hpd_pkg::OP_MUL_D: begin
                    r_acc  <= r_acc + W'($signed({1'b0, r_kd}) * w_diff) * W'(10000);
                    r_prev <= r_err;
                end
                hpd_pkg::OP_PID_MAG: begin
                    r_neg    <= r_acc[W-1];
                    r_sat    <= (w_acc_mag >= W'(hpd_pkg::PID_SAT_MAG));
                    r_mag_hi <= w_acc_mag[33:12];
                end
                hpd_pkg::OP_PID_Q: begin
                    r_pid <= r_neg ? -$signed({1'b0, w_pid_mag}) : $signed({1'b0, w_pid_mag});
                end
                hpd_pkg::OP_MIX: begin
                    r_side_l <= 15'(r_cruise) - 15'(r_pid);
                    r_side_r <= 15'(r_cruise) + 15'(r_pid);
                end
                hpd_pkg::OP_COMP: begin
                    if (w_div_done)
                        r_comp <= r_in_range ? w_quo[12:0] : 13'(hpd_pkg::COMP_ONE);
                end
                hpd_pkg::OP_MUL_L: r_prod_l <= r_side_l * $signed({1'b0, r_comp});
                hpd_pkg::OP_MUL_R: r_prod_r <= r_side_r * $signed({1'b0, r_comp});
                hpd_pkg::OP_CLAMP: begin
                    r_left  <= clamp(r_prod_l);
                    r_right <= clamp(r_prod_r);
                end
                default: ;
            endcase
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_run_enable  = r_run;
    assign o_left_cmd    = r_left;
    assign o_right_cmd   = r_right;
    assign o_comp_factor = r_comp;
    assign o_battery_mv  = r_mv;
endmodule

@@ hw/rtl/hpd_ctrl.sv @@
// Controller state machine sequencing one tick through the datapath.
`timescale 1ns / 1ps

module hpd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall,
    input  logic             i_run_enable,
    input  hpd_pkg::t_status i_status,
    output hpd_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_valid
);
    hpd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= hpd_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpd_pkg::S_IDLE:      if (i_valid && i_run_enable) n_state = hpd_pkg::S_MV;
            hpd_pkg::S_MV:        n_state = hpd_pkg::S_SUM;
            hpd_pkg::S_SUM:       n_state = hpd_pkg::S_MUL_P;
            hpd_pkg::S_MUL_P:     n_state = hpd_pkg::S_MUL_I;
            hpd_pkg::S_MUL_I:     n_state = hpd_pkg::S_MUL_D;
            hpd_pkg::S_MUL_D:     n_state = hpd_pkg::S_PID_MAG;
            hpd_pkg::S_PID_MAG:   n_state = hpd_pkg::S_PID_Q;
            hpd_pkg::S_PID_Q:     n_state = hpd_pkg::S_MIX;
            hpd_pkg::S_MIX:       n_state = hpd_pkg::S_COMP_WAIT;
            hpd_pkg::S_COMP_WAIT: if (i_status.div_done) n_state = hpd_pkg::S_MUL_L;
            hpd_pkg::S_MUL_L:     n_state = hpd_pkg::S_MUL_R;
            hpd_pkg::S_MUL_R:     n_state = hpd_pkg::S_CLAMP;
            hpd_pkg::S_CLAMP:     n_state = hpd_pkg::S_OUT;
            hpd_pkg::S_OUT:       if (!i_stall) n_state = hpd_pkg::S_IDLE;
            default:              n_state = hpd_pkg::S_IDLE;
        endcase
    end

    // Commands per state.
    always_comb begin
        o_cmd.op        = hpd_pkg::OP_NONE;
        o_cmd.div_start = 1'b0;
        o_in_stall      = 1'b1;
        o_valid         = 1'b0;
        unique case (r_state)
            hpd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid && i_run_enable) o_cmd.op = hpd_pkg::OP_LOAD;
            end
            hpd_pkg::S_MV: begin
                o_cmd.op = hpd_pkg::OP_MV;
                o_cmd.div_start = 1'b1;
            end
            hpd_pkg::S_SUM:       o_cmd.op = hpd_pkg::OP_SUM;
            hpd_pkg::S_MUL_P:     o_cmd.op = hpd_pkg::OP_MUL_P;
            hpd_pkg::S_MUL_I:     o_cmd.op = hpd_pkg::OP_MUL_I;
            hpd_pkg::S_MUL_D:     o_cmd.op = hpd_pkg::OP_MUL_D;
            hpd_pkg::S_PID_MAG:   o_cmd.op = hpd_pkg::OP_PID_MAG;
            hpd_pkg::S_PID_Q:     o_cmd.op = hpd_pkg::OP_PID_Q;
            hpd_pkg::S_MIX:       o_cmd.op = hpd_pkg::OP_MIX;
            hpd_pkg::S_COMP_WAIT: o_cmd.op = hpd_pkg::OP_COMP;
            hpd_pkg::S_MUL_L:     o_cmd.op = hpd_pkg::OP_MUL_L;
            hpd_pkg::S_MUL_R:     o_cmd.op = hpd_pkg::OP_MUL_R;
            hpd_pkg::S_CLAMP:     o_cmd.op = hpd_pkg::OP_CLAMP;
            hpd_pkg::S_OUT:       o_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the heading PID drive with battery compensation.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic signed [9:0] left;
        logic signed [9:0] right;
        logic [12:0]       comp;
        logic [13:0]       mv;
    } t_drive_cmd;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [2:0] REG_NONE = 3'd7;

    // Scoreboard: shadows the block's registers and state and queues the expected commands.
    class drive_scoreboard;
        logic              enable;
        logic signed [15:0] target;
        logic [15:0]       kp, ki, kd;
        logic [8:0]        limit, cruise;
        longint            err_sum, prev_err;
        t_drive_cmd        pending[$];
        int                errors;
        int                n_checked;

        function void reset_state();
            enable = 1'b0; target = 16'sd3000; kp = 16'd256; ki = 16'd0; kd = 16'd26;
            limit = 9'd300; cruise = 9'd150; err_sum = 0; prev_err = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                hpd_pkg::REG_RUN_ENABLE: enable = data[0];
                hpd_pkg::REG_TARGET:     target = data;
                hpd_pkg::REG_GAIN_P:     kp = data;
                hpd_pkg::REG_GAIN_I:     ki = data;
                hpd_pkg::REG_GAIN_D:     kd = data;
                hpd_pkg::REG_SPEED_LIM:  limit = data[8:0];
                hpd_pkg::REG_CRUISE:     cruise = data[8:0];
                default: ;
            endcase
        endfunction

        function longint wheel_cmd(longint side, longint comp);
            longint w;
            w = (side * comp) / hpd_pkg::COMP_ONE;
            if (w > longint'(limit)) w = limit;
            if (w < -longint'(limit)) w = -longint'(limit);
            return w;
        endfunction

        // Steer and compensate for one accepted tick.
        function void note_tick(logic signed [15:0] yaw, logic [11:0] code);
            longint prod, comp, e, smax, num, pid;
            t_drive_cmd c;
            if (!enable) return;
            prod = longint'(code) * 13200;
            if (prod >= 64'sd6000 * 4095 && prod <= 64'sd8400 * 4095)
                comp = (64'sd8400 * 4095 * 4096) / prod;
            else
                comp = hpd_pkg::COMP_ONE;
            e = longint'(target) - longint'(yaw);
            smax = (64'sd1 <<< (hpd_pkg::SUM_BITS - 1)) - 1;
            err_sum = err_sum + e;
            if (err_sum > smax) err_sum = smax;
            if (err_sum < -smax - 1) err_sum = -smax - 1;
            num = longint'(ki) * err_sum + longint'(kp) * e * 100
                + longint'(kd) * (e - prev_err) * 10000;
            pid = num / hpd_pkg::PID_DEN;
            if (pid > hpd_pkg::PID_SAT) pid = hpd_pkg::PID_SAT;
            if (pid < -hpd_pkg::PID_SAT) pid = -hpd_pkg::PID_SAT;
            prev_err = e;
            c.left  = 10'(wheel_cmd(longint'(cruise) - pid, comp));
            c.right = 10'(wheel_cmd(longint'(cruise) + pid, comp));
            c.comp  = 13'(comp);
            c.mv    = 14'(prod / 4095);
            pending.push_back(c);
        endfunction

        function void check_cmd(t_drive_cmd got);
            t_drive_cmd x;
            n_checked++;
            if (pending.size() == 0) begin
                $error("drive command with none expected");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.left !== x.left) begin
                $error("left_cmd: expected %0d, actual %0d", x.left, got.left); errors++;
            end
            if (got.right !== x.right) begin
                $error("right_cmd: expected %0d, actual %0d", x.right, got.right); errors++;
            end
            if (got.comp !== x.comp) begin
                $error("comp_factor: expected %0d, actual %0d", x.comp, got.comp); errors++;
            end
            if (got.mv !== x.mv) begin
                $error("battery_mv: expected %0d, actual %0d", x.mv, got.mv); errors++;
            end
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = hpd_pkg::REG_RUN_ENABLE;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_yaw_angle = '0;
    logic [11:0]        i_battery_code = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [9:0]  o_left_cmd, o_right_cmd;
    logic [12:0]        o_comp_factor;
    logic [13:0]        o_battery_mv;

    drive_scoreboard sb = new();
    longint cycles = 0;
    int     n_ticks = 0;
    int     n_phases = 0;

    heading_pid_drive_with_battery_comp_top u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("heading_pid_drive_with_battery_comp_top verification failed");
            $finish;
        end
    end

    // Check every completed result transfer.
    always @(posedge i_clk) begin
        t_drive_cmd got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.left = o_left_cmd; got.right = o_right_cmd;
            got.comp = o_comp_factor; got.mv = o_battery_mv;
            sb.check_cmd(got);
        end
    end

    // Receiver back-pressure: the stall pattern switches to a random mode after each random span.
    always @(negedge i_clk) begin
        int mode, span;
        if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 400);
        end
        span--;
        case (mode)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 99) < 30);
            2: i_stall = (cycles % 5 < 2);
            default: i_stall = ($urandom_range(0, 99) < 75);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_all(logic en, logic [15:0] tgt, logic [15:0] gp, logic [15:0] gi,
                           logic [15:0] gd, logic [8:0] lim, logic [8:0] cru);
        write_reg(hpd_pkg::REG_RUN_ENABLE, {15'd0, en});
        write_reg(hpd_pkg::REG_TARGET, tgt);
        write_reg(hpd_pkg::REG_GAIN_P, gp);
        write_reg(hpd_pkg::REG_GAIN_I, gi);
        write_reg(hpd_pkg::REG_GAIN_D, gd);
        write_reg(hpd_pkg::REG_SPEED_LIM, {7'd0, lim});
        write_reg(hpd_pkg::REG_CRUISE, {7'd0, cru});
        n_phases++;
    endtask

    // Wait for all expected commands, then idle before the next settings are written.
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One tick transfer; valid stays high when the next one follows directly.
    task automatic send_tick(logic [15:0] yaw, logic [11:0] code, bit hold);
        i_valid = 1'b1; i_yaw_angle = yaw; i_battery_code = code;
        do @(posedge i_clk); while (o_stall);
        sb.note_tick(yaw, code);
        n_ticks++;
        @(negedge i_clk);
        if (!hold) i_valid = 1'b0;
    endtask

    function automatic logic [11:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 12'($urandom_range(1861, 2607));
        if (r < 6) return (r % 2) ? 12'd0 : 12'hFFF;
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [15:0] pick_yaw(logic signed [15:0] near);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'(near + $urandom_range(0, 1200) - 600);
        if (r < 8) return 16'($urandom_range(0, 36000) - 18000);
        return 16'($urandom);
    endfunction

    task automatic random_phase(int count);
        int burst, gap;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 10);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                repeat (gap) @(negedge i_clk);
            end
            burst--;
            send_tick(pick_yaw(sb.target), pick_code(), burst != 0 && k != count - 1);
        end
    endtask

    initial begin
        logic [15:0] yaw_dir[9];
        logic [11:0] code_dir[9];
        sb.reset_state();
        sb.errors = 0;
        sb.n_checked = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, voltage window edges, disabled tick, large correction.
        yaw_dir  = '{16'h8000, 16'h7FFF, -16'sd18000, 16'sd18000, 16'd0,
                     16'sd3000, 16'sd2999, 16'sd2900, 16'sd3100};
        code_dir = '{12'd0, 12'hFFF, 12'd1861, 12'd1862, 12'd2606,
                     12'd2607, 12'd2000, 12'd1, 12'd2300};
        send_tick(16'd0, 12'd2000, 1'b0);
        write_reg(REG_NONE, 16'hFFFF);
        write_reg(hpd_pkg::REG_RUN_ENABLE, 16'd1);
        for (int k = 0; k < 9; k++) send_tick(yaw_dir[k], code_dir[k], k != 8);
        drain();
        set_all(1'b1, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'h1FF);
        for (int k = 0; k < 9; k++) send_tick(yaw_dir[8 - k], code_dir[k], 1'b0);
        drain();
        set_all(1'b1, 16'h8000, 16'd0, 16'd0, 16'd0, 9'd0, 9'd0);
        for (int k = 0; k < 5; k++) send_tick(yaw_dir[k], code_dir[k], 1'b0);
        drain();

        // Random phases with varied settings, including a disabled one.
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: set_all(1'b1, 16'sd3000, 16'd256, 16'd0, 16'd26, 9'd300, 9'd150);
                1: set_all(1'b1, -16'sd18000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd300, 9'd300);
                2: set_all(1'b0, 16'sd18000, 16'd512, 16'd64, 16'd40, 9'd200, 9'd100);
                3: set_all(1'b1, 16'sd18000, 16'd0, 16'd0, 16'd0, 9'd511, 9'd0);
                default: set_all(1'b1, 16'($urandom_range(0, 36000) - 18000),
                                 16'($urandom_range(0, 1024)), 16'($urandom_range(0, 2048)),
                                 16'($urandom_range(0, 300)), 9'($urandom_range(0, 511)),
                                 9'($urandom_range(0, 511)));
            endcase
            random_phase(160);
            drain();
        end

        $display("Ran %0d ticks over %0d register settings; %0d drive commands checked.",
                 n_ticks, n_phases, sb.n_checked);
        if (sb.pending.size() != 0) begin
            $error("%0d expected drive commands never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("heading_pid_drive_with_battery_comp_top verification clean");
        else
            $display("heading_pid_drive_with_battery_comp_top verification failed");
        $finish;
    end

endmodule
